// ===== src/dgw_pkg.sv =====
// Shared types and constants for the grid walker.
`timescale 1ns / 1ps
package dgw_pkg;

    localparam int COORD_W = 7;
    localparam int TDATA_W = 32;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W+1:0] scoord_t;

    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_SEED   = 3'd1;
    localparam logic [2:0] ACT_LAUNCH = 3'd2;
    localparam logic [2:0] ACT_WALK   = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_MOVED  = 2'd1;
    localparam logic [1:0] ST_FROZEN = 2'd2;
    localparam logic [1:0] ST_ERROR  = 2'd3;

    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_MARGIN = 2'd2;

    function automatic coord_t eff_dim(input logic [6:0] v, input int maxv);
        coord_t r;
        if (v < 7'd2) begin
            r = coord_t'(2);
        end else if (int'(v) > maxv) begin
            r = coord_t'(maxv);
        end else begin
            r = coord_t'(v);
        end
        return r;
    endfunction

    // Neighbor offsets, column then row, the center skipped.
    function automatic logic signed [1:0] nbr_dx(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0, 3'd1, 3'd2: d = -2'sd1;
            3'd3, 3'd4:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] nbr_dy(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0, 3'd3, 3'd5: d = -2'sd1;
            3'd1, 3'd6:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    function automatic scoord_t tri_val(input logic [1:0] v);
        scoord_t r;
        case (v)
            2'd0:    r = scoord_t'(0);
            2'd1:    r = scoord_t'(1);
            default: r = -scoord_t'(1);
        endcase
        return r;
    endfunction

endpackage

// ===== src/dgw_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module dgw_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/dla_grid_walker_unit.sv =====
// Lattice aggregation engine: occupancy grid, bounding box and one walker.
// A walk step reads the grid memory for each of the 8 neighbors in turn.
// Clear sweeps the whole grid, one cell written per cycle, then reports done.
// One item at a time; the next is accepted once the sequencer is back in idle.
// After reset the grid is swept empty before any item is taken, with no result.
`timescale 1ns / 1ps
module dla_grid_walker_unit #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int ORDER_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // action[2:0] cell_x[8:3] cell_y[14:9] launch_offset[20:15] coin_y[21]
    // tri_y[23:22] coin_x[24] tri_x[26:25]
    input  logic [dgw_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // status[1:0] pos_x[7:2] pos_y[13:8] order[25:14] occupied[26]
    output logic [dgw_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_addr,
    input  logic [6:0]                cfg_wdata
);
    import dgw_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = ORDER_BITS + 1;
    localparam logic [ORDER_BITS-1:0] ORDER_MAX = {ORDER_BITS{1'b1}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd1;
    localparam logic [2:0] S_CLR    = 3'd2;
    localparam logic [2:0] S_CLRDN  = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_NBR    = 3'd5;
    localparam logic [2:0] S_WALK   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [6:0] rows_reg, rows_next, cols_reg, cols_next;
    logic [3:0] margin_reg, margin_next;
    logic [2:0] act_reg, act_next;
    logic [5:0] cx_reg, cx_next, cy_reg, cy_next, off_reg, off_next;
    logic       coin_y_reg, coin_y_next, coin_x_reg, coin_x_next;
    logic [1:0] ty_reg, ty_next, tx_reg, tx_next;
    coord_t     bminx_reg, bminx_next, bmaxx_reg, bmaxx_next;
    coord_t     bminy_reg, bminy_next, bmaxy_reg, bmaxy_next;
    logic [ORDER_BITS-1:0] next_order_reg, next_order_next;
    logic       active_reg, active_next;
    coord_t     wx_reg, wx_next, wy_reg, wy_next;
    logic [3:0] k_reg, k_next;
    logic       pend_reg, pend_next, hit_reg, hit_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic       clr_report_reg, clr_report_next;
    logic       m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0] m_data_reg, m_data_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [MW-1:0] ram_wdata, ram_rdata;

    coord_t  nr, nc;
    scoord_t lo_x, hi_x, lo_y, hi_y, xs, xe, ys, ye, span;
    scoord_t cl_x, cl_y, nx, ny, mv_x, mv_y;
    logic    launch_ok, cell_ok, nbr_ok, out_free, emit;
    logic [1:0]  o_status;
    coord_t      o_px, o_py;
    logic [ORDER_BITS-1:0] o_ord;
    logic        o_occ;

    function automatic logic [AW-1:0] cell_addr(input coord_t x, input coord_t y);
        return AW'(AW'(x) * AW'(MAX_ROWS) + AW'(y));
    endfunction

    dgw_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    always_comb begin
        nr   = eff_dim(rows_reg, MAX_ROWS);
        nc   = eff_dim(cols_reg, MAX_COLS);
        lo_x = scoord_t'(bminx_reg) - scoord_t'(margin_reg);
        hi_x = scoord_t'(bmaxx_reg) + scoord_t'(margin_reg);
        lo_y = scoord_t'(bminy_reg) - scoord_t'(margin_reg);
        hi_y = scoord_t'(bmaxy_reg) + scoord_t'(margin_reg);
        xs   = (lo_x < 0) ? scoord_t'(0) : lo_x;
        ys   = (lo_y < 0) ? scoord_t'(0) : lo_y;
        xe   = (hi_x > scoord_t'(nc) - 1) ? scoord_t'(nc) - 1 : hi_x;
        ye   = (hi_y > scoord_t'(nr) - 1) ? scoord_t'(nr) - 1 : hi_y;
        span = xe - xs;
        launch_ok = (span > 0) && (scoord_t'(off_reg) < span) && (ys <= ye);
        cell_ok   = (coord_t'(cx_reg) < nc) && (coord_t'(cy_reg) < nr);

        cl_x = scoord_t'(wx_reg);
        if (cl_x < lo_x) cl_x = xs;
        if (cl_x > hi_x) cl_x = xe;
        if (cl_x > scoord_t'(nc) - 1) cl_x = scoord_t'(nc) - 1;
        cl_y = scoord_t'(wy_reg);
        if (cl_y < lo_y) cl_y = ys;
        if (cl_y > hi_y) cl_y = ye;
        if (cl_y > scoord_t'(nr) - 1) cl_y = scoord_t'(nr) - 1;

        nx = scoord_t'(wx_reg) + scoord_t'(nbr_dx(k_reg[2:0]));
        ny = scoord_t'(wy_reg) + scoord_t'(nbr_dy(k_reg[2:0]));
        nbr_ok = (nx >= 0) && (ny >= 0) && (nx < scoord_t'(nc)) && (ny < scoord_t'(nr));

        if (wy_reg == '0) begin
            mv_y = scoord_t'(wy_reg) + scoord_t'(coin_y_reg);
        end else if (wy_reg == nr - coord_t'(1)) begin
            mv_y = scoord_t'(wy_reg) - scoord_t'(coin_y_reg);
        end else begin
            mv_y = scoord_t'(wy_reg) + tri_val(ty_reg);
        end
        if (wx_reg == '0) begin
            mv_x = scoord_t'(wx_reg) + scoord_t'(coin_x_reg);
        end else if (wx_reg == nc - coord_t'(1)) begin
            mv_x = scoord_t'(wx_reg) - scoord_t'(coin_x_reg);
        end else begin
            mv_x = scoord_t'(wx_reg) + tri_val(tx_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        margin_next     = margin_reg;
        act_next        = act_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        off_next        = off_reg;
        coin_y_next     = coin_y_reg;
        coin_x_next     = coin_x_reg;
        ty_next         = ty_reg;
        tx_next         = tx_reg;
        bminx_next      = bminx_reg;
        bmaxx_next      = bmaxx_reg;
        bminy_next      = bminy_reg;
        bmaxy_next      = bmaxy_reg;
        next_order_next = next_order_reg;
        active_next     = active_reg;
        wx_next         = wx_reg;
        wy_next         = wy_reg;
        k_next          = k_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        emit      = 1'b0;
        o_status  = ST_ERROR;
        o_px      = '0;
        o_py      = '0;
        o_ord     = '0;
        o_occ     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    act_next    = s_axis_tdata[2:0];
                    cx_next     = s_axis_tdata[8:3];
                    cy_next     = s_axis_tdata[14:9];
                    off_next    = s_axis_tdata[20:15];
                    coin_y_next = s_axis_tdata[21];
                    ty_next     = s_axis_tdata[23:22];
                    coin_x_next = s_axis_tdata[24];
                    tx_next     = s_axis_tdata[26:25];
                    state_next  = S_DEC;
                end
            end
            S_DEC: begin
                case (act_reg)
                    ACT_CLEAR: begin
                        bminx_next      = nc - coord_t'(1);
                        bmaxx_next      = '0;
                        bminy_next      = nr - coord_t'(1);
                        bmaxy_next      = '0;
                        next_order_next = ORDER_BITS'(1);
                        active_next     = 1'b0;
                        wx_next         = '0;
                        wy_next         = '0;
                        clr_addr_next   = '0;
                        clr_report_next = 1'b1;
                        state_next      = S_CLR;
                    end
                    ACT_SEED: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (cell_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = cell_addr(coord_t'(cx_reg), coord_t'(cy_reg));
                                ram_wdata = MW'(1) << ORDER_BITS;
                                if (coord_t'(cx_reg) < bminx_reg) bminx_next = coord_t'(cx_reg);
                                if (coord_t'(cx_reg) > bmaxx_reg) bmaxx_next = coord_t'(cx_reg);
                                if (coord_t'(cy_reg) < bminy_reg) bminy_next = coord_t'(cy_reg);
                                if (coord_t'(cy_reg) > bmaxy_reg) bmaxy_next = coord_t'(cy_reg);
                                o_status = ST_DONE;
                                o_px     = coord_t'(cx_reg);
                                o_py     = coord_t'(cy_reg);
                                o_occ    = 1'b1;
                            end
                        end
                    end
                    ACT_LAUNCH: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (launch_ok) begin
                                wx_next     = coord_t'(xs + scoord_t'(off_reg));
                                wy_next     = coord_t'(ys);
                                active_next = 1'b1;
                                o_status    = ST_DONE;
                                o_px        = coord_t'(xs + scoord_t'(off_reg));
                                o_py        = coord_t'(ys);
                            end
                        end
                    end
                    ACT_WALK: begin
                        if (active_reg) begin
                            wx_next    = coord_t'(cl_x);
                            wy_next    = coord_t'(cl_y);
                            k_next     = '0;
                            pend_next  = 1'b0;
                            hit_next   = 1'b0;
                            state_next = S_NBR;
                        end else if (out_free) begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    ACT_READ: begin
                        if (cell_ok) begin
                            ram_re     = 1'b1;
                            ram_raddr  = cell_addr(coord_t'(cx_reg), coord_t'(cy_reg));
                            state_next = S_RD;
                        end else if (out_free) begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_CLR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = clr_report_reg ? S_CLRDN : S_IDLE;
                end
            end
            S_CLRDN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    o_status   = ST_DONE;
                    state_next = S_IDLE;
                end
            end
            S_RD: begin
                if (out_free) begin
                    emit       = 1'b1;
                    o_status   = ST_DONE;
                    o_px       = coord_t'(cx_reg);
                    o_py       = coord_t'(cy_reg);
                    o_occ      = ram_rdata[ORDER_BITS];
                    o_ord      = ram_rdata[ORDER_BITS] ? ram_rdata[ORDER_BITS-1:0] : '0;
                    state_next = S_IDLE;
                end
            end
            S_NBR: begin
                if (k_reg != '0) begin
                    hit_next = hit_reg | (pend_reg & ram_rdata[ORDER_BITS]);
                end
                if (k_reg == 4'd8) begin
                    state_next = S_WALK;
                end else begin
                    ram_re    = nbr_ok;
                    ram_raddr = cell_addr(coord_t'(nx), coord_t'(ny));
                    pend_next = nbr_ok;
                    k_next    = k_reg + 4'd1;
                end
            end
            S_WALK: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    o_px       = wx_reg;
                    o_py       = wy_reg;
                    if (hit_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = cell_addr(wx_reg, wy_reg);
                        ram_wdata = {1'b1, next_order_reg};
                        if (wx_reg < bminx_reg) bminx_next = wx_reg;
                        if (wx_reg > bmaxx_reg) bmaxx_next = wx_reg;
                        if (wy_reg < bminy_reg) bminy_next = wy_reg;
                        if (wy_reg > bmaxy_reg) bmaxy_next = wy_reg;
                        if (next_order_reg != ORDER_MAX) begin
                            next_order_next = next_order_reg + ORDER_BITS'(1);
                        end
                        active_next = 1'b0;
                        o_status    = ST_FROZEN;
                        o_ord       = next_order_reg;
                    end else begin
                        wx_next  = coord_t'(mv_x);
                        wy_next  = coord_t'(mv_y);
                        o_px     = coord_t'(mv_x);
                        o_py     = coord_t'(mv_y);
                        o_status = ST_MOVED;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we) begin
            case (cfg_addr)
                REG_ROWS: begin
                    rows_next   = cfg_wdata;
                    active_next = 1'b0;
                end
                REG_COLS: begin
                    cols_next   = cfg_wdata;
                    active_next = 1'b0;
                end
                REG_MARGIN: margin_next = cfg_wdata[3:0];
                default: ;
            endcase
        end

        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = TDATA_W'({o_occ, 12'(o_ord), o_py[5:0], o_px[5:0], o_status});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            rows_reg       <= 7'd64;
            cols_reg       <= 7'd64;
            margin_reg     <= 4'd4;
            bminx_reg      <= eff_dim(7'd64, MAX_COLS) - coord_t'(1);
            bmaxx_reg      <= '0;
            bminy_reg      <= eff_dim(7'd64, MAX_ROWS) - coord_t'(1);
            bmaxy_reg      <= '0;
            next_order_reg <= ORDER_BITS'(1);
            active_reg     <= 1'b0;
            wx_reg         <= '0;
            wy_reg         <= '0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rows_reg       <= rows_next;
            cols_reg       <= cols_next;
            margin_reg     <= margin_next;
            bminx_reg      <= bminx_next;
            bmaxx_reg      <= bmaxx_next;
            bminy_reg      <= bminy_next;
            bmaxy_reg      <= bmaxy_next;
            next_order_reg <= next_order_next;
            active_reg     <= active_next;
            wx_reg         <= wx_next;
            wy_reg         <= wy_next;
            k_reg          <= k_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        off_reg    <= off_next;
        coin_y_reg <= coin_y_next;
        coin_x_reg <= coin_x_next;
        ty_reg     <= ty_next;
        tx_reg     <= tx_next;
        m_data_reg <= m_data_next;
    end
endmodule

// ===== src/dgw_checker.sv =====
// Port-level checks for the grid walker, bound to the top level.
`timescale 1ns / 1ps
module dgw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in work");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared from idle");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && !s_axis_tready)
        else $error("outputs active after reset");
endmodule

bind dla_grid_walker_unit dgw_checker u_dgw_checker (.*);
